>>> rtl/spar_pkg.sv
package spar_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int TIME_BITS = 16;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam int FUNC_W = 2;
	localparam int USED_W = 6;
	localparam int KIND_W = 2;
	localparam int OUTC_W = 7;
	localparam int CAP_W  = 7;

	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam logic [KIND_W-1:0] KIND_FREE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OLDEST  = 2'd2;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef struct packed {
		time_t age;
		time_t life;
		logic  resp;
	} slot_t;

	typedef struct packed {
		logic  active;
		logic  expired;
		logic  greater;
		time_t new_age;
	} alu_out_t;

endpackage

>>> rtl/slot_pool_age_replacement.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   func, delta_time, entry_lifespan, entry_respawn
// out      output     out_valid / out_stall slot_used, was_replacement, active_count, fill_count
// cfg      input      cfg_valid / cfg_ready cfg_data (capacity)
//
// A tick reads the occupied slots and an add into a full pool reads the first capacity slots, through
// the slot memory's single read port, which is scanned one slot per cycle.
// An add into a free slot, a tick on an empty pool, a clear and an unused code skip the scan.
// Reset empties the pool and sets capacity to 64; slot contents are not cleared.
// The input is stalled while an item is in work; a stalled result holds in the output register.
module slot_pool_age_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [spar_pkg::FUNC_W-1:0]    func,
	input  spar_pkg::time_t                delta_time,
	input  spar_pkg::time_t                entry_lifespan,
	input  logic                           entry_respawn,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [spar_pkg::USED_W-1:0]    slot_used,
	output logic [spar_pkg::KIND_W-1:0]    was_replacement,
	output logic [spar_pkg::OUTC_W-1:0]    active_count,
	output logic [spar_pkg::OUTC_W-1:0]    fill_count,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [spar_pkg::CAP_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;

	localparam logic [spar_pkg::CNT_W-1:0] MAX_CNT = spar_pkg::CNT_W'(spar_pkg::MAX_SLOTS);

	logic [1:0]                      state_q;
	logic [spar_pkg::CAP_W-1:0]      cap_q;
	logic [spar_pkg::CNT_W-1:0]      occ_q;
	logic [spar_pkg::CNT_W-1:0]      cap_eff;
	logic [spar_pkg::FUNC_W-1:0]     func_q;
	spar_pkg::time_t                 delta_q;
	spar_pkg::time_t                 life_q;
	logic                            resp_q;
	logic [spar_pkg::CNT_W-1:0]      n_q;
	logic [spar_pkg::CNT_W-1:0]      rd_idx_q;
	logic                            vld_s1;
	logic [spar_pkg::SLOT_W-1:0]     idx_s1;
	logic [spar_pkg::CNT_W-1:0]      act_cnt_q;
	logic                            found_q;
	logic [spar_pkg::SLOT_W-1:0]     fidx_q;
	spar_pkg::time_t                 best_q;
	logic [spar_pkg::SLOT_W-1:0]     bidx_q;
	logic [spar_pkg::USED_W-1:0]     res_used_q;
	logic [spar_pkg::KIND_W-1:0]     res_kind_q;
	logic [spar_pkg::OUTC_W-1:0]     res_act_q;
	logic [spar_pkg::OUTC_W-1:0]     res_fill_q;
	logic                            out_valid_q;

	logic                            acc;
	logic                            rd_en;
	logic                            scan_done;
	logic                            add_free;
	logic [spar_pkg::SLOT_W-1:0]     chosen;
	logic                            we;
	logic [spar_pkg::SLOT_W-1:0]     waddr;
	spar_pkg::slot_t                 wdata;
	spar_pkg::slot_t                 rdata;
	spar_pkg::alu_out_t              alu;

	assign in_stall  = state_q != ST_IDLE;
	assign acc       = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = spar_pkg::CNT_W'(1);
		end else if (spar_pkg::CNT_W'(cap_q) > MAX_CNT) begin
			cap_eff = MAX_CNT;
		end else begin
			cap_eff = spar_pkg::CNT_W'(cap_q);
		end
	end

	assign add_free  = occ_q < cap_eff;
	assign rd_en     = state_q == ST_SCAN && rd_idx_q < n_q;
	assign scan_done = state_q == ST_SCAN && !rd_en && !vld_s1;
	assign chosen    = found_q ? fidx_q : bidx_q;

	spar_slot_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[spar_pkg::SLOT_W-1:0]),
		.rdata (rdata)
	);

	spar_age_alu u_alu (
		.slot  (rdata),
		.delta (delta_q),
		.best  (best_q),
		.res   (alu)
	);

	always_comb begin
		we    = 1'b0;
		waddr = occ_q[spar_pkg::SLOT_W-1:0];
		wdata = '{age: '0, life: entry_lifespan, resp: entry_respawn};
		if (acc && func == spar_pkg::FUNC_ADD && add_free) begin
			we = 1'b1;
		end else if (state_q == ST_SCAN && vld_s1 && func_q == spar_pkg::FUNC_TICK
			&& alu.active) begin
			we    = 1'b1;
			waddr = idx_s1;
			wdata = '{age: alu.new_age, life: rdata.life, resp: rdata.resp};
		end else if (scan_done && func_q == spar_pkg::FUNC_ADD) begin
			we    = 1'b1;
			waddr = chosen;
			wdata = '{age: '0, life: life_q, resp: resp_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= spar_pkg::CAP_W'(64);
			occ_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			vld_s1 <= rd_en;
			if (state_q == ST_RES && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (func)
							spar_pkg::FUNC_TICK: begin
								state_q <= (occ_q == '0) ? ST_RES : ST_SCAN;
							end
							spar_pkg::FUNC_ADD: begin
								if (add_free) begin
									occ_q   <= occ_q + 1'b1;
									state_q <= ST_RES;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							spar_pkg::FUNC_CLEAR: begin
								occ_q   <= '0;
								state_q <= ST_RES;
							end
							default: begin
								state_q <= ST_RES;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_q     <= func;
			delta_q    <= delta_time;
			life_q     <= entry_lifespan;
			resp_q     <= entry_respawn;
			rd_idx_q   <= '0;
			act_cnt_q  <= '0;
			found_q    <= 1'b0;
			n_q        <= (func == spar_pkg::FUNC_TICK) ? occ_q : cap_eff;
			res_kind_q <= spar_pkg::KIND_FREE;
			res_act_q  <= '0;
			case (func)
				spar_pkg::FUNC_ADD: begin
					res_used_q <= spar_pkg::USED_W'(occ_q);
					res_fill_q <= spar_pkg::OUTC_W'(occ_q + 1'b1);
				end
				spar_pkg::FUNC_CLEAR: begin
					res_used_q <= '0;
					res_fill_q <= '0;
				end
				default: begin
					res_used_q <= '0;
					res_fill_q <= spar_pkg::OUTC_W'(occ_q);
				end
			endcase
		end
		if (rd_en) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			idx_s1   <= rd_idx_q[spar_pkg::SLOT_W-1:0];
		end
		if (state_q == ST_SCAN && vld_s1) begin
			if (func_q == spar_pkg::FUNC_TICK) begin
				if (alu.active) begin
					act_cnt_q <= act_cnt_q + 1'b1;
				end
			end else if (!found_q) begin
				if (alu.expired) begin
					found_q <= 1'b1;
					fidx_q  <= idx_s1;
				end else if (idx_s1 == '0 || alu.greater) begin
					best_q <= rdata.age;
					bidx_q <= idx_s1;
				end
			end
		end
		if (scan_done) begin
			res_fill_q <= spar_pkg::OUTC_W'(occ_q);
			if (func_q == spar_pkg::FUNC_TICK) begin
				res_act_q <= spar_pkg::OUTC_W'(act_cnt_q);
			end else begin
				res_used_q <= spar_pkg::USED_W'(chosen);
				res_kind_q <= found_q ? spar_pkg::KIND_EXPIRED : spar_pkg::KIND_OLDEST;
			end
		end
		if (state_q == ST_RES && (!out_valid_q || !out_stall)) begin
			slot_used       <= res_used_q;
			was_replacement <= res_kind_q;
			active_count    <= res_act_q;
			fill_count      <= res_fill_q;
		end
	end

endmodule

>>> rtl/spar_slot_mem.sv
module spar_slot_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [spar_pkg::SLOT_W-1:0]  waddr,
	input  spar_pkg::slot_t              wdata,
	input  logic                         re,
	input  logic [spar_pkg::SLOT_W-1:0]  raddr,
	output spar_pkg::slot_t              rdata
);

	spar_pkg::slot_t mem [spar_pkg::MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/spar_age_alu.sv
module spar_age_alu (
	input  spar_pkg::slot_t    slot,
	input  spar_pkg::time_t    delta,
	input  spar_pkg::time_t    best,
	output spar_pkg::alu_out_t res
);

	logic [spar_pkg::TIME_BITS:0] sum;
	spar_pkg::time_t              sat;

	always_comb begin
		sum = {1'b0, slot.age} + {1'b0, delta};
		sat = sum[spar_pkg::TIME_BITS] ? {spar_pkg::TIME_BITS{1'b1}}
			: sum[spar_pkg::TIME_BITS-1:0];
		res.active  = slot.age < slot.life;
		res.expired = slot.age > slot.life;
		res.greater = slot.age > best;
		res.new_age = (sat > slot.life && slot.resp) ? '0 : sat;
	end

endmodule

>>> rtl/spar_checker.sv
module spar_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [spar_pkg::USED_W-1:0] slot_used,
	input logic [spar_pkg::KIND_W-1:0] was_replacement,
	input logic [spar_pkg::OUTC_W-1:0] active_count,
	input logic [spar_pkg::OUTC_W-1:0] fill_count
);

	localparam logic [spar_pkg::OUTC_W-1:0] FILL_MAX = spar_pkg::OUTC_W'(spar_pkg::MAX_SLOTS);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_used)
			&& $stable(was_replacement) && $stable(active_count) && $stable(fill_count))
		else $error("stalled result changed");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_count <= FILL_MAX)
		else $error("fill count above slot count");

	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> active_count <= fill_count)
		else $error("active count above fill count");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_replacement != spar_pkg::KIND_FREE |->
			(was_replacement == spar_pkg::KIND_EXPIRED
			|| was_replacement == spar_pkg::KIND_OLDEST)
			&& spar_pkg::OUTC_W'(slot_used) < fill_count)
		else $error("replacement slot outside the pool");

endmodule

bind slot_pool_age_replacement spar_checker u_spar_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.slot_used       (slot_used),
	.was_replacement (was_replacement),
	.active_count    (active_count),
	.fill_count      (fill_count)
);

>>> dv/tb_slot_pool_age_replacement.sv
`timescale 1ns / 100ps

module tb_slot_pool_age_replacement;

	localparam int unsigned AGE_CEIL    = (1 << spar_pkg::TIME_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned LONG_HOLD   = 400;

	typedef struct packed {
		logic [spar_pkg::FUNC_W-1:0] func;
		spar_pkg::time_t             delta;
		spar_pkg::time_t             life;
		logic                        resp;
	} pool_op_t;

	typedef struct packed {
		logic [spar_pkg::USED_W-1:0] slot;
		logic [spar_pkg::KIND_W-1:0] kind;
		logic [spar_pkg::OUTC_W-1:0] active;
		logic [spar_pkg::OUTC_W-1:0] fill;
	} pool_res_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [spar_pkg::FUNC_W-1:0]   func = spar_pkg::FUNC_TICK;
	spar_pkg::time_t               delta_time = '0;
	spar_pkg::time_t               entry_lifespan = '0;
	logic                          entry_respawn = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [spar_pkg::USED_W-1:0]   slot_used;
	logic [spar_pkg::KIND_W-1:0]   was_replacement;
	logic [spar_pkg::OUTC_W-1:0]   active_count;
	logic [spar_pkg::OUTC_W-1:0]   fill_count;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [spar_pkg::CAP_W-1:0]    cfg_data = '0;

	slot_pool_age_replacement uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.delta_time      (delta_time),
		.entry_lifespan  (entry_lifespan),
		.entry_respawn   (entry_respawn),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.slot_used       (slot_used),
		.was_replacement (was_replacement),
		.active_count    (active_count),
		.fill_count      (fill_count),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always #10 clk = ~clk;

	spar_pkg::time_t            slot_age_m [spar_pkg::MAX_SLOTS];
	spar_pkg::time_t            slot_life_m [spar_pkg::MAX_SLOTS];
	logic                       slot_resp_m [spar_pkg::MAX_SLOTS];
	int unsigned                pool_fill;
	logic [spar_pkg::CAP_W-1:0] pool_capacity;

	pool_op_t  pending_ops [$];
	pool_res_t pool_results_due [$];
	pool_op_t  offered_op;
	pool_res_t predicted_res;
	pool_res_t arrived_res;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_done;
	int unsigned hold_left;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned cycle_count;
	int unsigned capacity_writes = 0;
	int unsigned ops_sent [4] = '{0, 0, 0, 0};
	int unsigned adds_by_kind [4] = '{0, 0, 0, 0};

	function automatic pool_res_t apply_pool_op(input pool_op_t op);
		pool_res_t       res;
		int unsigned     cap;
		int unsigned     pick;
		int unsigned     sum;
		int unsigned     active;
		spar_pkg::time_t oldest;
		bit              hit;
		res = '0;
		active = 0;
		case (op.func)
			spar_pkg::FUNC_TICK: begin
				for (int i = 0; i < pool_fill; i++) begin
					if (slot_age_m[i] < slot_life_m[i]) begin
						active++;
						sum = slot_age_m[i] + op.delta;
						slot_age_m[i] = (sum > AGE_CEIL) ? spar_pkg::time_t'(AGE_CEIL)
							: spar_pkg::time_t'(sum);
						if (slot_age_m[i] > slot_life_m[i] && slot_resp_m[i])
							slot_age_m[i] = '0;
					end
				end
			end
			spar_pkg::FUNC_ADD: begin
				if (pool_capacity == 0)
					cap = 1;
				else if (pool_capacity > spar_pkg::MAX_SLOTS)
					cap = spar_pkg::MAX_SLOTS;
				else
					cap = pool_capacity;
				if (pool_fill < cap) begin
					pick = pool_fill;
					pool_fill++;
					res.kind = spar_pkg::KIND_FREE;
				end else begin
					oldest = slot_age_m[0];
					pick = 0;
					hit = 1'b0;
					for (int i = 0; i < cap && !hit; i++) begin
						if (slot_age_m[i] > slot_life_m[i]) begin
							pick = i;
							hit = 1'b1;
						end else if (slot_age_m[i] > oldest) begin
							oldest = slot_age_m[i];
							pick = i;
						end
					end
					res.kind = hit ? spar_pkg::KIND_EXPIRED : spar_pkg::KIND_OLDEST;
				end
				slot_age_m[pick] = '0;
				slot_life_m[pick] = op.life;
				slot_resp_m[pick] = op.resp;
				res.slot = pick[spar_pkg::USED_W-1:0];
			end
			spar_pkg::FUNC_CLEAR: begin
				pool_fill = 0;
			end
			default: begin
			end
		endcase
		res.active = active[spar_pkg::OUTC_W-1:0];
		res.fill = pool_fill[spar_pkg::OUTC_W-1:0];
		return res;
	endfunction

	function automatic spar_pkg::time_t random_span();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return spar_pkg::time_t'($urandom_range(300));
		else if (roll < 60)
			return spar_pkg::time_t'($urandom_range(4000));
		else if (roll < 80)
			return spar_pkg::time_t'($urandom);
		else if (roll < 90)
			return '0;
		else
			return spar_pkg::time_t'($urandom_range(AGE_CEIL, AGE_CEIL - 6000));
	endfunction

	function automatic pool_op_t random_pool_op();
		pool_op_t    op;
		int unsigned roll;
		roll = $urandom_range(999);
		if (roll < 470)
			op.func = spar_pkg::FUNC_ADD;
		else if (roll < 950)
			op.func = spar_pkg::FUNC_TICK;
		else if (roll < 975)
			op.func = spar_pkg::FUNC_CLEAR;
		else
			op.func = spar_pkg::FUNC_UNUSED;
		op.delta = ($urandom_range(3) == 0) ? random_span()
			: spar_pkg::time_t'($urandom_range(150));
		op.life = random_span();
		op.resp = 1'($urandom_range(1));
		return op;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= spar_pkg::FUNC_TICK;
			delta_time <= '0;
			entry_lifespan <= '0;
			entry_respawn <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_res = apply_pool_op(offered_op);
				pool_results_due.insert(pool_results_due.size(), predicted_res);
				ops_sent[offered_op.func]++;
				if (offered_op.func == spar_pkg::FUNC_ADD)
					adds_by_kind[predicted_res.kind]++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					offered_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					func <= offered_op.func;
					delta_time <= offered_op.delta;
					entry_lifespan <= offered_op.life;
					entry_respawn <= offered_op.resp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pool_results_due.size() == 0) begin
					$error("result transfer with nothing expected: slot_used %0d fill_count %0d",
						slot_used, fill_count);
					mismatches++;
				end else begin
					arrived_res = pool_results_due.pop_front();
					results_checked++;
					if (slot_used !== arrived_res.slot) begin
						$error("slot_used mismatch: expected %0d, got %0d",
							arrived_res.slot, slot_used);
						mismatches++;
					end
					if (was_replacement !== arrived_res.kind) begin
						$error("was_replacement mismatch: expected %0d, got %0d",
							arrived_res.kind, was_replacement);
						mismatches++;
					end
					if (active_count !== arrived_res.active) begin
						$error("active_count mismatch: expected %0d, got %0d",
							arrived_res.active, active_count);
						mismatches++;
					end
					if (fill_count !== arrived_res.fill) begin
						$error("fill_count mismatch: expected %0d, got %0d",
							arrived_res.fill, fill_count);
						mismatches++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
			out_stall <= (hold_left > 1) || (hold_req && !hold_done) ||
				($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic wait_pool_quiet();
		while (pending_ops.size() != 0 || in_valid || pool_results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [spar_pkg::CAP_W-1:0] value);
		wait_pool_quiet();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		pool_capacity = value;
		capacity_writes++;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		@(posedge clk);
		tx_idle_pct <= tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	task automatic queue_op(input logic [spar_pkg::FUNC_W-1:0] f, input int unsigned d,
		input int unsigned l, input logic r);
		pool_op_t op;
		op.func = f;
		op.delta = spar_pkg::time_t'(d);
		op.life = spar_pkg::time_t'(l);
		op.resp = r;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	initial begin
		int unsigned cap_pick;
		pool_fill = 0;
		pool_capacity = 7'd64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A small pool makes replacement reachable within a few items.
		set_idling(22, 85);
		set_capacity(7'd4);
		queue_op(spar_pkg::FUNC_TICK, 5, 0, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, 0, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, AGE_CEIL, 1'b1);
		queue_op(spar_pkg::FUNC_ADD, 0, 100, 1'b1);
		queue_op(spar_pkg::FUNC_ADD, 0, 50, 1'b0);
		queue_op(spar_pkg::FUNC_TICK, 60, 0, 1'b0);
		queue_op(spar_pkg::FUNC_TICK, 60, 0, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, 300, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, 7, 1'b1);
		queue_op(spar_pkg::FUNC_UNUSED, AGE_CEIL, AGE_CEIL, 1'b1);
		queue_op(spar_pkg::FUNC_TICK, AGE_CEIL, 0, 1'b0);
		queue_op(spar_pkg::FUNC_TICK, AGE_CEIL, 0, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, AGE_CEIL, 1'b0);
		set_capacity(7'd2);
		queue_op(spar_pkg::FUNC_ADD, 0, 10, 1'b1);
		queue_op(spar_pkg::FUNC_TICK, 0, 0, 1'b0);
		set_capacity(7'd0);
		queue_op(spar_pkg::FUNC_ADD, 0, 20, 1'b0);
		queue_op(spar_pkg::FUNC_CLEAR, 0, 0, 1'b0);
		queue_op(spar_pkg::FUNC_ADD, 0, 1, 1'b1);
		queue_op(spar_pkg::FUNC_ADD, 0, 2, 1'b0);
		set_capacity(7'd127);
		queue_op(spar_pkg::FUNC_ADD, 0, 400, 1'b1);
		queue_op(spar_pkg::FUNC_TICK, 40, 0, 1'b0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: cap_pick = 64;
				1: cap_pick = 0;
				2: cap_pick = $urandom_range(63, 2);
				3: cap_pick = 127;
				4: cap_pick = 1;
				default: cap_pick = $urandom_range(64, 1);
			endcase
			set_capacity(cap_pick[spar_pkg::CAP_W-1:0]);
			if (phase < 2)
				set_idling(22, 85);
			else if (phase < 4)
				set_idling(85, 22);
			else
				set_idling(0, 0);
			// The receiver holds off while items keep coming, so the block backs up.
			if (phase == 4) begin
				@(posedge clk);
				hold_req <= 1'b1;
			end
			for (int n = 0; n < 90; n++) begin
				pending_ops.insert(pending_ops.size(), random_pool_op());
				if (phase == 5 && n == 45)
					wait_pool_quiet();
			end
		end

		wait_pool_quiet();
		repeat (80) @(posedge clk);
		$display("Covered %0d ticks, %0d adds, %0d clears, %0d unused codes; %0d results checked",
			ops_sent[spar_pkg::FUNC_TICK], ops_sent[spar_pkg::FUNC_ADD],
			ops_sent[spar_pkg::FUNC_CLEAR], ops_sent[spar_pkg::FUNC_UNUSED],
			results_checked);
		$display("Adds went to %0d free, %0d expired and %0d oldest slots over %0d capacity writes",
			adds_by_kind[spar_pkg::KIND_FREE], adds_by_kind[spar_pkg::KIND_EXPIRED],
			adds_by_kind[spar_pkg::KIND_OLDEST], capacity_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
